[sv/ddw_pkg.sv]
// ============================================================================
// ddw_pkg: shared types and constants for the date difference block
// Field widths, order codes, reciprocal constants and the month table.
// ============================================================================
package ddw_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DAYS_W  = 22;
    localparam int ORDER_W = 2;
    localparam int WDAY_W  = 3;
    localparam int DNUM_W  = 23;

    typedef logic [DNUM_W-1:0] t_daynum;

    // Order of date A against date B.
    typedef enum logic [ORDER_W-1:0] {
        ORDER_BEFORE = 2'd0,
        ORDER_EQUAL  = 2'd1,
        ORDER_AFTER  = 2'd2
    } t_order;

    // Division by 100 through a reciprocal, exact for operands below 2^15.
    localparam int DIV100_MUL = 20972;
    localparam int DIV100_SH  = 21;

    // Division by 7 through a reciprocal, exact for operands below 2^23.
    localparam int DIV7_MUL = 9586981;
    localparam int DIV7_SH  = 26;

    // Days before the first of each month in a common year, by month index.
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mi);
        logic [8:0] v;
        unique case (mi)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Weekday anchor: Monday, the 21st of April 2025.
    localparam int REF_YEAR  = 2025;
    localparam int REF_MONTH = 4;
    localparam int REF_DAY   = 21;
    localparam int REF_LEAP  =
        (((REF_YEAR % 4 == 0) && (REF_YEAR % 100 != 0)) || (REF_YEAR % 400 == 0))
        && (REF_MONTH > 2) ? 1 : 0;
    localparam int REF_DNUM  = 365 * REF_YEAR + (REF_YEAR + 3) / 4
                             - (REF_YEAR + 99) / 100 + (REF_YEAR + 399) / 400
                             + int'(days_before(4'(REF_MONTH - 1)))
                             + REF_LEAP + REF_DAY;
    localparam int WDAY_ADJ  = (7 - (REF_DNUM % 7)) % 7;

endpackage

[sv/ddw_day_number.sv]
// ============================================================================
// ddw_day_number: three-stage day number pipeline for one date
// Turns year, month and day into a running day count in closed form.
// ============================================================================
module ddw_day_number (
    input  logic                          i_clk,
    input  logic [ddw_pkg::YEAR_W-1:0]    i_year,
    input  logic [ddw_pkg::MONTH_W-1:0]   i_month,
    input  logic [ddw_pkg::DAY_W-1:0]     i_day,
    output ddw_pkg::t_daynum              o_daynum
);
    import ddw_pkg::*;

    // Stage 1 combinational signals.
    logic [MONTH_W-1:0] w_mclamp;
    logic [MONTH_W-1:0] w_mi;
    logic [14:0]        w_y_p99;
    logic [14:0]        w_y_p399;
    logic [29:0]        w_p100;
    logic [27:0]        w_p400;

    // Stage 1 registers.
    logic [YEAR_W-1:0] r1_year;
    logic [12:0]       r1_q4;
    logic [7:0]        r1_q100;
    logic [5:0]        r1_q400;
    logic [9:0]        r1_mday;
    logic              r1_late;

    // Stage 2 combinational signals and registers.
    logic              w_div100;
    logic              w_div400;
    logic              w_leap;
    logic [DNUM_W-1:0] r2_prod;
    logic [12:0]       r2_qsum;
    logic [9:0]        r2_mday;
    logic              r2_adj;

    // Stage 1: clamp the month and take the ceilings by 4, 100 and 400.
    always_comb begin
        if (i_month == 4'd0) begin
            w_mclamp = 4'd1;
        end else if (i_month > 4'd12) begin
            w_mclamp = 4'd12;
        end else begin
            w_mclamp = i_month;
        end
        w_mi     = w_mclamp - 4'd1;
        w_y_p99  = {1'b0, i_year} + 15'd99;
        w_y_p399 = {1'b0, i_year} + 15'd399;
        w_p100   = 30'(w_y_p99) * 30'(DIV100_MUL);
        w_p400   = 28'(w_y_p399[14:2]) * 28'(DIV100_MUL);
    end

    always_ff @(posedge i_clk) begin
        r1_year <= i_year;
        r1_q4   <= 13'(({1'b0, i_year} + 15'd3) >> 2);
        r1_q100 <= 8'(w_p100 >> DIV100_SH);
        r1_q400 <= 6'(w_p400 >> DIV100_SH);
        r1_mday <= 10'(days_before(w_mi)) + 10'(i_day);
        r1_late <= (w_mi >= 4'd2);
    end

    // Stage 2: leap year test, year term and century corrections.
    always_comb begin
        w_div100 = ((15'(r1_q100) * 15'd100) == {1'b0, r1_year});
        w_div400 = ((15'(r1_q400) * 15'd400) == {1'b0, r1_year});
        w_leap   = ((r1_year[1:0] == 2'd0) && !w_div100) || w_div400;
    end

    always_ff @(posedge i_clk) begin
        r2_prod <= DNUM_W'(r1_year) * DNUM_W'(365);
        r2_qsum <= r1_q4 - 13'(r1_q100) + 13'(r1_q400);
        r2_mday <= r1_mday;
        r2_adj  <= r1_late & w_leap;
    end

    // Stage 3: add up the day number.
    always_ff @(posedge i_clk) begin
        o_daynum <= r2_prod + DNUM_W'(r2_qsum) + DNUM_W'(r2_mday) + DNUM_W'(r2_adj);
    end

endmodule

[sv/date_difference_and_weekday_top.sv]
// ============================================================================
// date_difference_and_weekday_top: days between two dates and weekday of A
// The done strobe marks the result of each started date pair.
// Throughput is one date pair per cycle; busy is never raised.
// The depth is set by the day number pipeline (three stages) and the
// reciprocal division by seven (two stages).
// Synchronous active-low reset clears the valid bits; no words are in flight.
// ============================================================================
module date_difference_and_weekday_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ddw_pkg::YEAR_W-1:0]    i_year_a,
    input  logic [ddw_pkg::MONTH_W-1:0]   i_month_a,
    input  logic [ddw_pkg::DAY_W-1:0]     i_day_a,
    input  logic [ddw_pkg::YEAR_W-1:0]    i_year_b,
    input  logic [ddw_pkg::MONTH_W-1:0]   i_month_b,
    input  logic [ddw_pkg::DAY_W-1:0]     i_day_b,
    output logic                          o_done,
    output logic [ddw_pkg::DAYS_W-1:0]    o_days_between,
    output logic [ddw_pkg::ORDER_W-1:0]   o_order_code,
    output logic [ddw_pkg::WDAY_W-1:0]    o_weekday_a
);
    import ddw_pkg::*;

    localparam int DEPTH = 5;

    // Valid bits and the order code travel alongside the data.
    logic [DEPTH-1:0] r_vld;
    t_order           r_ord [DEPTH];
    t_order           w_order;

    // Day numbers from the two pipelines.
    t_daynum w_na;
    t_daynum w_nb;

    // Stage 4 signals and registers.
    logic [DNUM_W-1:0] w_diff;
    logic [46:0]       w_p7;
    logic [DAYS_W-1:0] r4_days;
    t_daynum           r4_na;
    logic [19:0]       r4_q7;

    // Stage 5 signals and registers.
    logic [2:0]        w_rem;
    logic [3:0]        w_wsum;
    logic [WDAY_W-1:0] n_wday;
    logic [DAYS_W-1:0] r_days;
    logic [WDAY_W-1:0] r_wday;

    assign busy = 1'b0;

    // Day number pipelines for both dates.
    ddw_day_number u_dnum_a (
        .i_clk    (i_clk),
        .i_year   (i_year_a),
        .i_month  (i_month_a),
        .i_day    (i_day_a),
        .o_daynum (w_na)
    );

    ddw_day_number u_dnum_b (
        .i_clk    (i_clk),
        .i_year   (i_year_b),
        .i_month  (i_month_b),
        .i_day    (i_day_b),
        .o_daynum (w_nb)
    );

    // Order compares the raw fields: year, then month, then day.
    always_comb begin
        priority if ((i_year_a > i_year_b) ||
                     ((i_year_a == i_year_b) && (i_month_a > i_month_b)) ||
                     ((i_year_a == i_year_b) && (i_month_a == i_month_b) &&
                      (i_day_a > i_day_b))) begin
            w_order = ORDER_AFTER;
        end else if ((i_year_a == i_year_b) && (i_month_a == i_month_b) &&
                     (i_day_a == i_day_b)) begin
            w_order = ORDER_EQUAL;
        end else begin
            w_order = ORDER_BEFORE;
        end
    end

    // Valid shift register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start & ~busy};
        end
    end

    // Order code delay line.
    always_ff @(posedge i_clk) begin
        r_ord[0] <= w_order;
        for (int i = 1; i < DEPTH; i++) begin
            r_ord[i] <= r_ord[i-1];
        end
    end

    // Stage 4: absolute difference and the quotient of A's day number by seven.
    always_comb begin
        w_diff = (w_na >= w_nb) ? (w_na - w_nb) : (w_nb - w_na);
        w_p7   = 47'(w_na) * 47'(DIV7_MUL);
    end

    always_ff @(posedge i_clk) begin
        r4_days <= w_diff[DNUM_W-1] ? {DAYS_W{1'b1}} : w_diff[DAYS_W-1:0];
        r4_na   <= w_na;
        r4_q7   <= 20'(w_p7 >> DIV7_SH);
    end

    // Stage 5: remainder by seven, shifted so that the anchor lands on Monday.
    always_comb begin
        w_rem  = 3'(r4_na - DNUM_W'(r4_q7) * DNUM_W'(7));
        w_wsum = 4'(w_rem) + 4'(WDAY_ADJ);
        n_wday = (w_wsum >= 4'd7) ? 3'(w_wsum - 4'd7) : 3'(w_wsum);
    end

    always_ff @(posedge i_clk) begin
        r_days <= r4_days;
        r_wday <= n_wday;
    end

    // Result word.
    assign o_done         = r_vld[DEPTH-1];
    assign o_days_between = r_days;
    assign o_order_code   = r_ord[DEPTH-1];
    assign o_weekday_a    = r_wday;

`ifndef SYNTHESIS
    // Every accepted word comes out as a done strobe.
    a_start_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##5 o_done)
        else $error("accepted word did not produce a result on time");

    // A result is only shown for an accepted word.
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 5))
        else $error("result strobe without an accepted word");

    // Identical dates are zero days apart.
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_order_code == ORDER_EQUAL)) |-> (o_days_between == '0))
        else $error("equal dates with a nonzero distance");

    // The weekday stays within Monday through Sunday.
    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_weekday_a != 3'd7))
        else $error("weekday out of range");
`endif

endmodule
